[hw/rtl/gsg_pkg.sv]
// Shared types, constants and the 5x7 glyph table for the glyph span generator.
// No dependencies; imported by every module of the block.
package gsg_pkg;

    localparam int GLYPH_WIDTH  = 5;
    localparam int GLYPH_HEIGHT = 7;
    localparam int NUM_GLYPHS   = 23;
    localparam logic [1:0] MAX_SCALE = 2'd3;
    localparam logic [4:0] ADVANCE   = 5'(GLYPH_WIDTH + 1);

    localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] REG_PIXEL_SCALE = 2'd2;

    typedef logic [GLYPH_WIDTH-1:0] glyph_row_t;
    typedef glyph_row_t [GLYPH_HEIGHT-1:0] glyph_t;

    typedef struct packed {
        logic load;
        logic step;
    } gsg_cmd_t;

    typedef struct packed {
        logic has_span;
        logic out_free;
        logic done;
        logic scale_zero;
    } gsg_sts_t;

    // Rows are listed bottom first, so the top row 0 sits in the lowest element.
    localparam glyph_t GLYPH_ROM [NUM_GLYPHS] = '{
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h0E, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h0E},
        '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0C, 5'h04},
        '{5'h1F, 5'h10, 5'h08, 5'h06, 5'h01, 5'h11, 5'h0E},
        '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h02, 5'h02, 5'h1F, 5'h12, 5'h0A, 5'h06, 5'h02},
        '{5'h1E, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h1F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10},
        '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
        '{5'h11, 5'h11, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h0D, 5'h12, 5'h15, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h12, 5'h14, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h10, 5'h10, 5'h0F},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}
    };

    function automatic logic [4:0] glyph_index(input logic [7:0] code);
        logic [7:0] up;
        logic [4:0] idx;
        up = code;
        if (code >= 8'h61 && code <= 8'h7A)
        begin
            up = code - 8'h20;
        end
        if (up >= 8'h30 && up <= 8'h35)
        begin
            idx = 5'd1 + up[4:0] - 5'd16;
        end
        else
        begin
            unique case (up)
                8'h41:   idx = 5'd7;
                8'h42:   idx = 5'd8;
                8'h43:   idx = 5'd9;
                8'h44:   idx = 5'd10;
                8'h45:   idx = 5'd11;
                8'h49:   idx = 5'd12;
                8'h4C:   idx = 5'd13;
                8'h4D:   idx = 5'd14;
                8'h4E:   idx = 5'd15;
                8'h4F:   idx = 5'd16;
                8'h51:   idx = 5'd17;
                8'h52:   idx = 5'd18;
                8'h53:   idx = 5'd19;
                8'h54:   idx = 5'd20;
                8'h55:   idx = 5'd21;
                8'h57:   idx = 5'd22;
                default: idx = 5'd0;
            endcase
        end
        return idx;
    endfunction

endpackage

[hw/rtl/gsg_ctrl.sv]
// Controller state machine for the glyph span generator.
// Depends on gsg_pkg for the command and status structs.
module gsg_ctrl
    import gsg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  gsg_sts_t sts,
    output gsg_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready = (state_reg == S_IDLE);
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.step = (state_reg == S_SCAN) && (!sts.has_span || sts.out_free);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load && !sts.scale_zero)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmd.step && sts.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !cmd.step)
        else $error("scan step issued while idle");

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && sts.done |=> state_reg == S_IDLE)
        else $error("controller did not return to idle after the final row");

    a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && !sts.scale_zero |=> state_reg == S_SCAN)
        else $error("controller did not start scanning after a transfer");

endmodule

[hw/rtl/gsg_datapath.sv]
// Datapath of the glyph span generator: glyph store, run finder, cursor and output register.
// Depends on gsg_pkg for the glyph table, the lookup function and the control structs.
module gsg_datapath
    import gsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  gsg_cmd_t    cmd,
    output gsg_sts_t    sts,
    input  logic [7:0]  char_code,
    input  logic        first_char,
    input  logic [15:0] origin_x,
    input  logic [15:0] origin_y,
    input  logic [1:0]  scale,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [15:0] span_x,
    output logic [15:0] span_y,
    output logic [3:0]  span_width,
    output logic        last_span
);

    glyph_t      glyph_reg;
    logic [2:0]  row_reg;
    logic [2:0]  row_inc;
    logic [1:0]  dy_reg;
    glyph_row_t  remain_reg;
    logic [15:0] y_reg;
    logic [15:0] cursor_reg;
    logic        out_valid_reg;
    logic [15:0] span_x_reg;
    logic [15:0] span_y_reg;
    logic [3:0]  span_width_reg;
    logic        last_span_reg;

    glyph_t      glyph_next;
    logic [2:0]  run_start;
    logic [2:0]  run_len;
    logic        found;
    logic        stop;
    glyph_row_t  clr_mask;
    glyph_row_t  remain_next;
    logic        dy_final;
    logic        tail_empty;
    logic        emit;

    assign glyph_next = GLYPH_ROM[glyph_index(char_code)];
    assign row_inc    = row_reg + 3'd1;

    always_comb
    begin
        run_start = 3'd0;
        run_len   = 3'd0;
        found     = 1'b0;
        stop      = 1'b0;
        clr_mask  = '0;
        for (int c = 0; c < GLYPH_WIDTH; c++)
        begin
            if (!found && remain_reg[GLYPH_WIDTH-1-c])
            begin
                run_start = 3'(c);
                found     = 1'b1;
            end
        end
        for (int c = 0; c < GLYPH_WIDTH; c++)
        begin
            if (found && (3'(c) >= run_start) && !stop)
            begin
                if (remain_reg[GLYPH_WIDTH-1-c])
                begin
                    run_len                   = run_len + 3'd1;
                    clr_mask[GLYPH_WIDTH-1-c] = 1'b1;
                end
                else
                begin
                    stop = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        tail_empty = 1'b1;
        for (int r = 0; r < GLYPH_HEIGHT; r++)
        begin
            if ((3'(r) > row_reg) && (glyph_reg[r] != '0))
            begin
                tail_empty = 1'b0;
            end
        end
    end

    assign remain_next    = remain_reg & ~clr_mask;
    assign dy_final       = (dy_reg == (scale - 2'd1));
    assign sts.has_span   = (remain_reg != '0);
    assign sts.out_free   = !out_valid_reg || m_tready;
    assign sts.done       = (remain_next == '0) && dy_final && tail_empty;
    assign sts.scale_zero = (scale == 2'd0);
    assign emit           = cmd.step && sts.has_span;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (first_char)
                begin
                    cursor_reg <= origin_x;
                end
            end
            else if (cmd.step && sts.done)
            begin
                cursor_reg <= cursor_reg + {11'd0, ADVANCE * {3'd0, scale}};
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            glyph_reg  <= glyph_next;
            row_reg    <= 3'd0;
            dy_reg     <= 2'd0;
            remain_reg <= glyph_next[0];
            y_reg      <= origin_y;
        end
        else if (cmd.step)
        begin
            if (remain_next != '0)
            begin
                remain_reg <= remain_next;
            end
            else if (!sts.done)
            begin
                y_reg <= y_reg + 16'd1;
                if (dy_final)
                begin
                    row_reg    <= row_inc;
                    dy_reg     <= 2'd0;
                    remain_reg <= glyph_reg[row_inc];
                end
                else
                begin
                    dy_reg     <= dy_reg + 2'd1;
                    remain_reg <= glyph_reg[row_reg];
                end
            end
        end
        if (emit)
        begin
            span_x_reg     <= cursor_reg + {12'd0, {1'b0, run_start} * {2'd0, scale}};
            span_y_reg     <= y_reg;
            span_width_reg <= {1'b0, run_len} * {2'd0, scale};
            last_span_reg  <= sts.done;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign span_x     = span_x_reg;
    assign span_y     = span_y_reg;
    assign span_width = span_width_reg;
    assign last_span  = last_span_reg;

    a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> span_width_reg != 4'd0)
        else $error("span presented with zero width");

    a_row_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> row_reg < 3'(GLYPH_HEIGHT))
        else $error("glyph row index ran past the last row");

    a_cursor_held: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.load && !(cmd.step && sts.done) |=> $stable(cursor_reg))
        else $error("cursor moved in the middle of a character");

endmodule

[hw/rtl/glyph_span_generator.sv]
// Top level of the glyph span generator: configuration registers, controller and datapath.
// Depends on gsg_pkg, gsg_ctrl and gsg_datapath.
//
//  Channel   Direction  Transfer contents
//  s_axis    in         tdata: char_code[7:0]; tuser: first_char
//  m_axis    out        tdata: span_x, span_y, span_width; tlast: last_span
//  cfg       in         cfg_index 0 origin_x, 1 origin_y, 2 pixel_scale
//
// A character is accepted, then scanned span by span, stepping through each pixel row
// without spans, and ends at the last span; the spans come from the single run finder.
// A blank character scans only its top row; with scale 0 a character is accepted but
// not scanned.
// Reset clears the configuration to origin 0, 0 and scale 1 and the cursor to 0.
// With m_tready low the held span waits in the output register and the scan pauses at its
// next span.
module glyph_span_generator
    import gsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // char_code[7:0]
    input  logic        s_tuser,     // first_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // span_x[15:0], span_y[31:16], span_width[35:32], zero
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [15:0] origin_x_reg;
    logic [15:0] origin_y_reg;
    logic [1:0]  pixel_scale_reg;
    logic [1:0]  scale;
    logic [15:0] span_x;
    logic [15:0] span_y;
    logic [3:0]  span_width;
    gsg_cmd_t    cmd;
    gsg_sts_t    sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            pixel_scale_reg <= 2'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:    origin_x_reg    <= cfg_wdata;
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata;
                REG_PIXEL_SCALE: pixel_scale_reg <= cfg_wdata[1:0];
                default:         ;
            endcase
        end
    end

    assign scale = (pixel_scale_reg > MAX_SCALE) ? MAX_SCALE : pixel_scale_reg;

    gsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gsg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .char_code  (s_tdata),
        .first_char (s_tuser),
        .origin_x   (origin_x_reg),
        .origin_y   (origin_y_reg),
        .scale      (scale),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .span_x     (span_x),
        .span_y     (span_y),
        .span_width (span_width),
        .last_span  (m_tlast)
    );

    assign m_tdata = {4'd0, span_width, span_y, span_x};

endmodule
